// ----- rtl/qr_data_segment_encoder_macros.svh -----
// Assertion macros shared by the QR data segment encoder RTL.
`ifndef QR_DATA_SEGMENT_ENCODER_MACROS_SVH
`define QR_DATA_SEGMENT_ENCODER_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define QRDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qrds assertion failed");
// Condition must never be true out of reset.
`define QRDS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("qrds forbidden condition");
`else
`define QRDS_ASSERT(lbl, clk, rst_n, prop)
`define QRDS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- rtl/qrds_pkg.sv -----
// Types, constants and helper functions of the QR data segment encoder.
package qrds_pkg;

  localparam int unsigned ACC_W    = 48;
  localparam int unsigned NB_W     = $clog2(ACC_W + 1);
  localparam int unsigned QD_DEPTH = 2;
  localparam int unsigned QD_PTR_W = (QD_DEPTH > 1) ? $clog2(QD_DEPTH) : 1;
  localparam int unsigned QD_CNT_W = $clog2(QD_DEPTH + 1);

  localparam logic [3:0] IND_NUMERIC = 4'b0001;
  localparam logic [3:0] IND_ALNUM   = 4'b0010;
  localparam logic [3:0] IND_BYTE    = 4'b0100;
  localparam logic [7:0] PAD_EC      = 8'b11101100;
  localparam logic [7:0] PAD_11      = 8'b00010001;
  localparam logic [10:0] ALNUM_MASK = 11'h7FF;

  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2
  } mode_e;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_PAD  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_ENCODE_MODE   = 2'd0,
    CFG_VERSION_CLASS = 2'd1,
    CFG_CHAR_COUNT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  encode_mode;
    logic [1:0]  version_class;
    logic [15:0] char_count;
  } cfg_t;

  // Codewords of one item, the first one most significant.
  typedef struct packed {
    logic [ACC_W-1:0] data;
    logic [2:0]       cnt;
    logic             pad;
    logic             err;
  } bundle_t;

  function automatic mode_e mode_of(input logic [1:0] raw);
    mode_e m;
    unique case (raw)
      2'd0:    m = MODE_NUMERIC;
      2'd1:    m = MODE_ALNUM;
      default: m = MODE_BYTE;
    endcase
    return m;
  endfunction

  function automatic logic [4:0] count_width(input mode_e m, input logic [1:0] vc);
    logic [4:0] w;
    unique case (m)
      MODE_NUMERIC: w = (vc == 2'd0) ? 5'd10 : ((vc == 2'd1) ? 5'd12 : 5'd14);
      MODE_ALNUM:   w = (vc == 2'd0) ? 5'd9  : ((vc == 2'd1) ? 5'd11 : 5'd13);
      default:      w = (vc == 2'd0) ? 5'd8  : 5'd16;
    endcase
    return w;
  endfunction

  // {valid, value} of an alphanumeric character.
  function automatic logic [6:0] alnum_lookup(input logic [7:0] c);
    logic [6:0] r;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 6'(c - 8'd48)};
    end else if (c >= "A" && c <= "Z") begin
      r = {1'b1, 6'(c - 8'd55)};
    end else begin
      unique case (c)
        " ":     r = {1'b1, 6'd36};
        "$":     r = {1'b1, 6'd37};
        "%":     r = {1'b1, 6'd38};
        "*":     r = {1'b1, 6'd39};
        "+":     r = {1'b1, 6'd40};
        "-":     r = {1'b1, 6'd41};
        ".":     r = {1'b1, 6'd42};
        "/":     r = {1'b1, 6'd43};
        ":":     r = {1'b1, 6'd44};
        default: r = 7'd0;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- rtl/qrds_front.sv -----
// Front end: message state, character classification and bit packing per item.
`include "qr_data_segment_encoder_macros.svh"
module qrds_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qrds_pkg::cfg_t   cfg_i,
  input  logic             accept_i,
  input  logic             op_i,
  input  logic [7:0]       char_byte_i,
  input  logic             is_last_char_i,
  output logic             enq_o,
  output qrds_pkg::bundle_t bundle_o
);
  import qrds_pkg::*;

  logic [6:0] acc_q, acc_d;
  logic [2:0] pend_q;
  logic [5:0] g0_q, g0_d, g1_q, g1_d;
  logic [1:0] fill_q, fill_d;
  logic       hdr_q, hdr_d, tog_q, tog_d, err_q, err_d;

  logic [ACC_W-1:0] acc;
  logic [NB_W-1:0]  nb;
  logic             pad;
  mode_e            m;
  logic [4:0]       cw;
  logic [15:0]      cmask;
  logic [3:0]       ind;
  logic [5:0]       cval;
  logic             cbad;
  logic [6:0]       alk;
  logic [15:0]      trip, pair;
  logic [2:0]       rem;

  function automatic logic [ACC_W-1:0] shl_or(input logic [ACC_W-1:0] a,
                                               input logic [15:0] v,
                                               input logic [4:0] w);
    logic [ACC_W-1:0] mask;
    mask = (ACC_W'(1) << w) - ACC_W'(1);
    return (a << w) | ({{(ACC_W-16){1'b0}}, v} & mask);
  endfunction

  always_comb begin
    m     = mode_of(cfg_i.encode_mode);
    cw    = count_width(m, cfg_i.version_class);
    cmask = 16'((17'd1 << cw) - 17'd1);
    unique case (m)
      MODE_NUMERIC: ind = IND_NUMERIC;
      MODE_ALNUM:   ind = IND_ALNUM;
      default:      ind = IND_BYTE;
    endcase
    alk  = alnum_lookup(char_byte_i);
    cval = 6'd0;
    cbad = 1'b0;
    unique case (m)
      MODE_NUMERIC: begin
        if (char_byte_i >= "0" && char_byte_i <= "9") cval = 6'(char_byte_i - 8'd48);
        else cbad = 1'b1;
      end
      MODE_ALNUM: begin
        cval = alk[5:0];
        cbad = !alk[6];
      end
      default: ;
    endcase
    trip = 16'(g0_q) * 16'd100 + 16'(g1_q) * 16'd10 + 16'(cval);
    pair = 16'(g0_q) * 16'd45 + 16'(cval);

    acc    = {{(ACC_W-7){1'b0}}, acc_q};
    nb     = NB_W'(pend_q);
    pad    = 1'b0;
    g0_d   = g0_q;
    g1_d   = g1_q;
    fill_d = fill_q;
    hdr_d  = hdr_q;
    tog_d  = tog_q;
    err_d  = err_q;

    if (op_i == OP_PAD) begin
      if (!hdr_q) begin
        acc   = {{(ACC_W-8){1'b0}}, (tog_q ? PAD_11 : PAD_EC)};
        nb    = NB_W'(8);
        pad   = 1'b1;
        tog_d = !tog_q;
      end
    end else begin
      if (!hdr_q) begin
        acc = shl_or(acc, {12'd0, ind}, 5'd4);
        nb  = nb + NB_W'(4);
        acc = shl_or(acc, cfg_i.char_count & cmask, cw);
        nb  = nb + NB_W'(cw);
      end
      hdr_d = 1'b1;
      err_d = err_q | cbad;
      unique case (m)
        MODE_NUMERIC: begin
          if (fill_q >= 2'd2) begin
            acc    = shl_or(acc, trip, 5'd10);
            nb     = nb + NB_W'(10);
            fill_d = 2'd0;
          end else begin
            if (fill_q[0]) g1_d = cval;
            else g0_d = cval;
            fill_d = fill_q + 2'd1;
          end
        end
        MODE_ALNUM: begin
          if (fill_q >= 2'd1) begin
            acc    = shl_or(acc, pair & 16'(ALNUM_MASK), 5'd11);
            nb     = nb + NB_W'(11);
            fill_d = 2'd0;
          end else begin
            g0_d   = cval;
            fill_d = 2'd1;
          end
        end
        default: begin
          acc = shl_or(acc, {8'd0, char_byte_i}, 5'd8);
          nb  = nb + NB_W'(8);
        end
      endcase
      if (is_last_char_i) begin
        unique case (m)
          MODE_NUMERIC: begin
            if (fill_d == 2'd1) begin
              acc = shl_or(acc, 16'(g0_d), 5'd4);
              nb  = nb + NB_W'(4);
            end else if (fill_d >= 2'd2) begin
              acc = shl_or(acc, 16'(g0_d) * 16'd10 + 16'(g1_d), 5'd7);
              nb  = nb + NB_W'(7);
            end
          end
          MODE_ALNUM: begin
            if (fill_d == 2'd1) begin
              acc = shl_or(acc, 16'(g0_d), 5'd6);
              nb  = nb + NB_W'(6);
            end else if (fill_d >= 2'd2) begin
              acc = shl_or(acc, (16'(g0_d) * 16'd45 + 16'(g1_d)) & 16'(ALNUM_MASK), 5'd11);
              nb  = nb + NB_W'(11);
            end
          end
          default: ;
        endcase
        acc = shl_or(acc, 16'd0, 5'd4);
        nb  = nb + NB_W'(4);
        if (nb[2:0] != 3'd0) begin
          acc = shl_or(acc, 16'd0, 5'(4'd8 - {1'b0, nb[2:0]}));
          nb  = nb + NB_W'(4'd8 - {1'b0, nb[2:0]});
        end
        g0_d   = 6'd0;
        g1_d   = 6'd0;
        fill_d = 2'd0;
        hdr_d  = 1'b0;
        tog_d  = 1'b0;
      end
    end

    rem           = nb[2:0];
    acc_d         = acc[6:0] & ((7'd1 << rem) - 7'd1);
    bundle_o.data = acc >> rem;
    bundle_o.cnt  = 3'(nb >> 3);
    bundle_o.pad  = pad;
    bundle_o.err  = err_d;
  end

  assign enq_o = accept_i && (bundle_o.cnt != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      g0_q   <= '0;
      g1_q   <= '0;
      fill_q <= '0;
      hdr_q  <= 1'b0;
      tog_q  <= 1'b0;
      err_q  <= 1'b0;
    end else if (accept_i) begin
      acc_q  <= acc_d;
      pend_q <= rem;
      g0_q   <= g0_d;
      g1_q   <= g1_d;
      fill_q <= fill_d;
      hdr_q  <= hdr_d;
      tog_q  <= tog_d;
      err_q  <= err_d;
    end
  end

  `QRDS_ASSERT_NEVER(a_idle_no_pending, clk_i, rst_ni, !hdr_q && pend_q != 3'd0)
  `QRDS_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q == 2'd3)
  `QRDS_ASSERT(a_err_sticky, clk_i, rst_ni, err_q |=> err_q)

endmodule

// ----- rtl/qrds_fifo.sv -----
// Short queue of per-item codeword bundles between front and back end.
module qrds_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  qrds_pkg::bundle_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output qrds_pkg::bundle_t data_o
);
  import qrds_pkg::*;

  bundle_t               mem_q [QD_DEPTH];
  logic [QD_PTR_W-1:0]   wr_q, rd_q;
  logic [QD_CNT_W-1:0]   cnt_q;
  logic                  do_push, do_pop;

  function automatic logic [QD_PTR_W-1:0] nxt(input logic [QD_PTR_W-1:0] p);
    return (p == QD_PTR_W'(QD_DEPTH - 1)) ? '0 : p + QD_PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == QD_CNT_W'(QD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= nxt(wr_q);
      if (do_pop) rd_q <= nxt(rd_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + QD_CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QD_CNT_W'(1);
    end
  end

endmodule

// ----- rtl/qrds_back.sv -----
// Back end: loads bundles into the result register and drains them one codeword per cycle while pop is asserted.
`include "qr_data_segment_encoder_macros.svh"
module qrds_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  qrds_pkg::bundle_t q_data_i,
  output logic              q_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        codeword_o,
  output logic              last_o,
  output logic              is_pad_o,
  output logic              invalid_seen_o
);
  import qrds_pkg::*;

  logic [ACC_W-1:0] data_q;
  logic [2:0]       cnt_q;
  logic             pad_q, err_q;
  logic             take;

  assign empty_o        = (cnt_q == 3'd0);
  assign take           = pop_i && !empty_o;
  assign q_pop_o        = q_valid_i && (empty_o || (take && cnt_q == 3'd1));
  assign codeword_o     = 8'(data_q >> {cnt_q - 3'd1, 3'b000});
  assign last_o         = (cnt_q == 3'd1);
  assign is_pad_o       = pad_q;
  assign invalid_seen_o = err_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i.data;
      pad_q  <= q_data_i.pad;
      err_q  <= q_data_i.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (q_pop_o) begin
      cnt_q <= q_data_i.cnt;
    end else if (take) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  `QRDS_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > 3'd6)
  `QRDS_ASSERT_NEVER(a_no_empty_bundle, clk_i, rst_ni, q_valid_i && q_data_i.cnt == 3'd0)
  `QRDS_ASSERT(a_drain_step, clk_i, rst_ni, take && cnt_q > 3'd1 |=> cnt_q == $past(cnt_q) - 3'd1)

endmodule

// ----- rtl/qr_data_segment_encoder.sv -----
// Top level of the QR data segment encoder: config registers, front, queue, back.
//
//   channel   direction  handshake               payload
//   cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//   item      in         push/full               op_i, char_byte_i, is_last_char_i
//   result    out        empty/pop               codeword_o, last_o, is_pad_o, invalid_seen_o
//
// One item is accepted per cycle while the bundle queue has room; the front end
// packs all bits of an item in that cycle. Results leave one codeword per cycle
// from the back end register while pop is asserted, so an item that yields k
// codewords holds the output until all k have been popped. Reset clears all message state and loads the register
// reset values. A stalled result side fills the two-entry queue, then full rises.
module qr_data_segment_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [7:0]  char_byte_i,
  input  logic        is_last_char_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  codeword_o,
  output logic        last_o,
  output logic        is_pad_o,
  output logic        invalid_seen_o
);
  import qrds_pkg::*;

  cfg_t    cfg_q;
  logic    accept, enq, q_full, q_valid, q_pop;
  bundle_t f_bundle, q_bundle;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.encode_mode   <= 2'd0;
      cfg_q.version_class <= 2'd0;
      cfg_q.char_count    <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENCODE_MODE:   cfg_q.encode_mode   <= cfg_data_i[1:0];
        CFG_VERSION_CLASS: cfg_q.version_class <= cfg_data_i[1:0];
        CFG_CHAR_COUNT:    cfg_q.char_count    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  qrds_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .op_i           (op_i),
    .char_byte_i    (char_byte_i),
    .is_last_char_i (is_last_char_i),
    .enq_o          (enq),
    .bundle_o       (f_bundle)
  );

  qrds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (f_bundle),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_bundle)
  );

  qrds_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_bundle),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .codeword_o     (codeword_o),
    .last_o         (last_o),
    .is_pad_o       (is_pad_o),
    .invalid_seen_o (invalid_seen_o)
  );

endmodule
